@@ sv/lesf_pkg.sv @@
// shared types and constants for the largest empty square finder
// no dependencies; imported by the interfaces and every module but the ram

package lesf_pkg;

	localparam int SIZE_W = 11;
	localparam int IDX_W  = 10;
	localparam int CHAR_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 1024;

	localparam logic [SIZE_W-1:0] RST_NUM_COLS   = 11'd1;
	localparam logic [SIZE_W-1:0] RST_NUM_ROWS   = 11'd1;
	localparam logic [CHAR_W-1:0] RST_EMPTY_CHAR = 8'd46;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_COLS   = 2'd0,
		CFG_NUM_ROWS   = 2'd1,
		CFG_EMPTY_CHAR = 2'd2
	} cfg_reg_t;

	// position of the cell being accepted, from the raster counters
	typedef struct packed {
		logic             last;
		logic             row0;
		logic             col0;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} scan_info_t;

	typedef struct packed {
		logic stall;
		logic wr_en;
		logic done;
	} core_stat_t;

endpackage

@@ sv/lesf_if.sv @@
// valid/ready channel interfaces for cells in and results out
// depends on lesf_pkg

interface cell_if import lesf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] cell_char;

	modport source (output valid, output cell_char, input ready);
	modport sink (input valid, input cell_char, output ready);
endinterface

interface result_if import lesf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] square_size;
	logic [IDX_W-1:0]  bottom_row;
	logic [IDX_W-1:0]  right_col;

	modport source (output valid, output square_size, output bottom_row, output right_col,
		input ready);
	modport sink (input valid, input square_size, input bottom_row, input right_col,
		output ready);
endinterface

@@ sv/lesf_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module lesf_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/lesf_scan.sv @@
// raster position counters: row and column of the next cell, end of row and grid
// depends on lesf_pkg

module lesf_scan import lesf_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [SIZE_W-1:0] num_cols,
	input  logic [SIZE_W-1:0] num_rows,
	output scan_info_t        info,
	output logic [AW-1:0]     rd_addr
);

	logic [IDX_W-1:0]  row_q, col_q;
	logic [SIZE_W-1:0] cols, rows;
	logic              col_end, row_end;

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (num_cols == '0) begin
			cols = SIZE_W'(1);
		end else if (32'(num_cols) > MAX_COLS) begin
			cols = SIZE_W'(MAX_COLS);
		end else begin
			cols = num_cols;
		end
		if (num_rows == '0) begin
			rows = SIZE_W'(1);
		end else if (32'(num_rows) > MAX_ROWS) begin
			rows = SIZE_W'(MAX_ROWS);
		end else begin
			rows = num_rows;
		end
	end

	assign col_end = ({1'b0, col_q} + SIZE_W'(1)) >= cols;
	assign row_end = ({1'b0, row_q} + SIZE_W'(1)) >= rows;

	assign info.last = col_end && row_end;
	assign info.row0 = (row_q == '0);
	assign info.col0 = (col_q == '0);
	assign info.row  = row_q;
	assign info.col  = col_q;

	assign rd_addr = (32'(col_q) < MAX_COLS) ? AW'(col_q) : AW'(MAX_COLS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

endmodule

@@ sv/lesf_core.sv @@
// update stage: line store read-modify-write with forwarding, best tracking,
// result register; depends on lesf_pkg and the result interface

module lesf_core import lesf_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  scan_info_t        info,
	input  logic [AW-1:0]     slot,
	input  logic [CHAR_W-1:0] cell_char,
	input  logic [CHAR_W-1:0] empty_char,
	input  logic [SIZE_W-1:0] rd_data,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [SIZE_W-1:0] wr_data,
	output core_stat_t        stat,
	result_if.source          results
);

	logic              valid_s1;
	scan_info_t        info_s1;
	logic [AW-1:0]     slot_s1;
	logic [CHAR_W-1:0] cell_s1;

	logic              fwd_valid_q;
	logic [AW-1:0]     fwd_addr_q;
	logic [SIZE_W-1:0] fwd_data_q;

	logic [SIZE_W-1:0] left_q, diag_q;
	logic [SIZE_W-1:0] best_size_q;
	logic [IDX_W-1:0]  best_row_q, best_col_q;

	logic              out_valid_q;
	logic [SIZE_W-1:0] out_size_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;

	logic              stall;
	logic [SIZE_W-1:0] up_mem, up, diag, left, m_ul, m_all, v;
	logic [SIZE_W-1:0] best_size_n;
	logic [IDX_W-1:0]  best_row_n, best_col_n;

	// grid end in this stage needs the result register free
	assign stall = valid_s1 && info_s1.last && out_valid_q && !results.ready;
	assign wr_en = valid_s1 && !stall;

	// the previous cell may have written this slot at the edge of our read
	assign up_mem = (fwd_valid_q && fwd_addr_q == slot_s1) ? fwd_data_q : rd_data;

	always_comb begin
		up   = info_s1.row0 ? '0 : up_mem;
		diag = (info_s1.row0 || info_s1.col0) ? '0 : diag_q;
		left = info_s1.col0 ? '0 : left_q;
		m_ul  = (up < left) ? up : left;
		m_all = (m_ul < diag) ? m_ul : diag;
		v = (cell_s1 == empty_char) ? m_all + SIZE_W'(1) : '0;

		best_size_n = best_size_q;
		best_row_n  = best_row_q;
		best_col_n  = best_col_q;
		if (v > best_size_q) begin
			best_size_n = v;
			best_row_n  = info_s1.row;
			best_col_n  = info_s1.col;
		end
	end

	assign wr_addr = slot_s1;
	assign wr_data = v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
			slot_s1 <= slot;
			cell_s1 <= cell_char;
		end
	end

	// held through a stall so the forward still matches the held read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (!stall) begin
			fwd_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
		if (wr_en) begin
			left_q <= v;
			diag_q <= up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (wr_en) begin
			if (info_s1.last) begin
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				best_size_q <= best_size_n;
				best_row_q  <= best_row_n;
				best_col_q  <= best_col_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en && info_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && info_s1.last) begin
			out_size_q <= best_size_n;
			out_row_q  <= best_row_n;
			out_col_q  <= best_col_n;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.square_size = out_size_q;
	assign results.bottom_row  = out_row_q;
	assign results.right_col   = out_col_q;

	assign stat.stall = stall;
	assign stat.wr_en = wr_en;
	assign stat.done  = wr_en && info_s1.last;

endmodule

@@ sv/largest_empty_square_finder.sv @@
// largest empty square finder: one cell byte per cycle when not stalled, raster order.
// the last cell's result goes through the update stage register, then the result register.
// throughput: one cell per cycle when not stalled, set by the line store's one read and
// one write port per cell; the previous cell's write is forwarded into the next read.
// input stalls only while a grid-ending cell waits for a full result register.
// reset clears counters, best and valid flags, loads default config; line store is not cleared

module largest_empty_square_finder import lesf_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cell_if.sink                  cells,
	result_if.source              results
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [SIZE_W-1:0] num_cols_q, num_rows_q;
	logic [CHAR_W-1:0] empty_char_q;

	logic              accept;
	scan_info_t        info;
	core_stat_t        stat;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [SIZE_W-1:0] rd_data, wr_data;
	logic              wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q   <= RST_NUM_COLS;
			num_rows_q   <= RST_NUM_ROWS;
			empty_char_q <= RST_EMPTY_CHAR;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NUM_COLS: begin
					num_cols_q <= cfg_data;
				end
				CFG_NUM_ROWS: begin
					num_rows_q <= cfg_data;
				end
				CFG_EMPTY_CHAR: begin
					empty_char_q <= cfg_data[CHAR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cells.ready = !stat.stall;
	assign accept      = cells.valid && cells.ready;

	lesf_scan #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.num_cols (num_cols_q),
		.num_rows (num_rows_q),
		.info     (info),
		.rd_addr  (rd_addr)
	);

	lesf_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (MAX_COLS)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	lesf_core #(
		.MAX_COLS (MAX_COLS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.info       (info),
		.slot       (rd_addr),
		.cell_char  (cells.cell_char),
		.empty_char (empty_char_q),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.stat       (stat),
		.results    (results)
	);

`ifndef SYNTHESIS
	// a cell taken in is either written back or held the next cycle
	a_accept_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> stat.wr_en || stat.stall)
		else $error("accepted cell neither written back nor held");

	// input back-pressure only comes from a blocked result
	a_ready_low_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cells.ready |-> results.valid && !results.ready)
		else $error("input stalled without a blocked result");

	// a finished grid shows up as a result in the next cycle
	a_done_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> results.valid)
		else $error("grid end did not produce a result");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking bench for largest_empty_square_finder: directed table, stall test, random grids
// depends on lesf_pkg, cell_if/result_if and the block itself

module tb_top;
	import lesf_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int LAT_PAD     = 4;
	localparam int END_PAD     = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_SHOWN   = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [SIZE_W-1:0] side;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
	} square_t;

	typedef enum logic {ROW_CFG, ROW_CELL} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  typed;
		square_t               want;
	} stim_row_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam int DIR_ROWS = 31;
	// cell rows carry the byte in data; typed rows hold the result of a grid-ending cell
	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_CELL, '0, 11'd46, 1'b1, '{11'd1, 10'd0, 10'd0}},
		'{ROW_CELL, '0, 11'd0, 1'b1, '{11'd0, 10'd0, 10'd0}},
		'{ROW_CELL, '0, 11'd255, 1'b1, '{11'd0, 10'd0, 10'd0}},
		'{ROW_CFG, CFG_EMPTY_CHAR, 11'd0, 1'b0, '0},
		'{ROW_CELL, '0, 11'd0, 1'b1, '{11'd1, 10'd0, 10'd0}},
		'{ROW_CFG, CFG_EMPTY_CHAR, 11'h7ff, 1'b0, '0},
		'{ROW_CELL, '0, 11'd255, 1'b1, '{11'd1, 10'd0, 10'd0}},
		'{ROW_CELL, '0, 11'd254, 1'b1, '{11'd0, 10'd0, 10'd0}},
		// unknown index leaves the empty byte alone
		'{ROW_CFG, CFG_UNUSED, 11'h7ff, 1'b0, '0},
		'{ROW_CELL, '0, 11'd255, 1'b1, '{11'd1, 10'd0, 10'd0}},
		// zero sizes act as one
		'{ROW_CFG, CFG_NUM_COLS, 11'd0, 1'b0, '0},
		'{ROW_CFG, CFG_NUM_ROWS, 11'd0, 1'b0, '0},
		'{ROW_CELL, '0, 11'd255, 1'b1, '{11'd1, 10'd0, 10'd0}},
		'{ROW_CFG, CFG_EMPTY_CHAR, 11'd46, 1'b0, '0},
		'{ROW_CFG, CFG_NUM_COLS, 11'd2, 1'b0, '0},
		'{ROW_CFG, CFG_NUM_ROWS, 11'd2, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b1, '{11'd2, 10'd1, 10'd1}},
		'{ROW_CFG, CFG_NUM_COLS, 11'd4, 1'b0, '0},
		'{ROW_CFG, CFG_NUM_ROWS, 11'd4, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0},
		'{ROW_CELL, '0, 11'd65, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0},
		// shrink mid-grid: row 1 col 2 is past both new limits, so the next cell ends the grid
		'{ROW_CFG, CFG_NUM_COLS, 11'd2, 1'b0, '0},
		'{ROW_CFG, CFG_NUM_ROWS, 11'd1, 1'b0, '0},
		'{ROW_CELL, '0, 11'd46, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	cell_if   cells_ch ();
	result_if results_ch ();

	largest_empty_square_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cells(cells_ch),
		.results(results_ch)
	);

	// predictor state
	logic [SIZE_W-1:0] reg_cols;
	logic [SIZE_W-1:0] reg_rows;
	logic [CHAR_W-1:0] reg_empty;
	logic [SIZE_W-1:0] side_line [DEF_MAX_COLS];
	logic [SIZE_W-1:0] diag_side;
	logic [SIZE_W-1:0] left_side;
	logic [IDX_W-1:0]  row_at;
	logic [IDX_W-1:0]  col_at;
	square_t           best;

	square_t corner_q [$];
	int      miss_count;
	int      cycle_count;
	int      cells_fed;
	int      grids_fed;
	int      tx_idle_pct;
	int      rx_stall_pct;
	int      hold_reqs;
	int      hold_seen;
	int      hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_size(input logic [SIZE_W-1:0] v, input int max_v);
		if (v == '0)
			return 1;
		if (int'(v) > max_v)
			return max_v;
		return int'(v);
	endfunction

	// one accepted cell through the square-size recurrence
	function automatic void scan_cell(input logic [CHAR_W-1:0] c, output bit done,
		output square_t res);
		int                cols;
		int                rows;
		logic [SIZE_W-1:0] up;
		logic [SIZE_W-1:0] dg;
		logic [SIZE_W-1:0] lf;
		logic [SIZE_W-1:0] m;
		logic [SIZE_W-1:0] v;
		cols = eff_size(reg_cols, DEF_MAX_COLS);
		rows = eff_size(reg_rows, DEF_MAX_ROWS);
		up = (row_at == '0) ? '0 : side_line[col_at];
		dg = (row_at == '0 || col_at == '0) ? '0 : diag_side;
		lf = (col_at == '0) ? '0 : left_side;
		m = (up < dg) ? up : dg;
		if (lf < m)
			m = lf;
		v = (c == reg_empty) ? m + 11'd1 : '0;
		side_line[col_at] = v;
		diag_side = up;
		left_side = v;
		if (v > best.side)
			best = '{v, row_at, col_at};
		done = 1'b0;
		res = best;
		if (int'(col_at) + 1 >= cols) begin
			col_at = '0;
			diag_side = '0;
			left_side = '0;
			if (int'(row_at) + 1 >= rows) begin
				done = 1'b1;
				row_at = '0;
				best = '0;
			end else begin
				row_at = row_at + 10'd1;
			end
		end else begin
			col_at = col_at + 10'd1;
		end
	endfunction

	task automatic feed_cell(input logic [CHAR_W-1:0] c, input logic typed, input square_t want);
		bit      done;
		square_t got;
		while ($urandom_range(99) < tx_idle_pct) begin
			cells_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cells_ch.valid <= 1'b1;
		cells_ch.cell_char <= c;
		do
			@(posedge clk);
		while (cells_ch.ready !== 1'b1);
		scan_cell(c, done, got);
		if (typed)
			corner_q.push_back(want);
		else if (done)
			corner_q.push_back(got);
	endtask

	// sender goes quiet until every expected result is out, then lets the pipe empty
	task automatic drain_results();
		cells_ch.valid <= 1'b0;
		while (corner_q.size() != 0)
			@(posedge clk);
		repeat (LAT_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_NUM_COLS: reg_cols = val;
			CFG_NUM_ROWS: reg_rows = val;
			CFG_EMPTY_CHAR: reg_empty = val[CHAR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic pick_setting();
		logic [CFG_DATA_W-1:0] cols;
		logic [CFG_DATA_W-1:0] rows;
		cols = ($urandom_range(15) == 0) ? 11'd0 :
			($urandom_range(7) == 0) ? 11'($urandom_range(7, 12)) : 11'($urandom_range(1, 6));
		rows = ($urandom_range(15) == 0) ? 11'd0 :
			($urandom_range(7) == 0) ? 11'($urandom_range(7, 12)) : 11'($urandom_range(1, 6));
		drain_results();
		write_reg(CFG_NUM_COLS, cols);
		write_reg(CFG_NUM_ROWS, rows);
		write_reg(CFG_EMPTY_CHAR, {3'($urandom_range(7)), 8'($urandom_range(255))});
		cfg_we <= 1'b0;
	endtask

	// one whole grid from its first cell; obstacles per mille, or raw bytes when noisy
	task automatic feed_grid(input int obst_pm, input bit noisy);
		int                cells;
		logic [CHAR_W-1:0] c;
		cells = eff_size(reg_cols, DEF_MAX_COLS) * eff_size(reg_rows, DEF_MAX_ROWS);
		for (int i = 0; i < cells; i++) begin
			if (noisy)
				c = 8'($urandom_range(255));
			else if ($urandom_range(999) < obst_pm)
				c = reg_empty ^ 8'($urandom_range(1, 255));
			else
				c = reg_empty;
			feed_cell(c, 1'b0, '0);
		end
		cells_fed += cells;
		grids_fed++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				tx_idle_pct = 0;
				rx_stall_pct <= 0;
			end
			IDLE_SENDER: begin
				tx_idle_pct = 53;
				rx_stall_pct <= 0;
			end
			IDLE_RECEIVER: begin
				tx_idle_pct = 0;
				rx_stall_pct <= 53;
			end
			default: begin
				tx_idle_pct = 32;
				rx_stall_pct <= 32;
			end
		endcase
	endtask

	task automatic report_miss(input string what, input int want, input int got);
		miss_count++;
		if (miss_count <= MAX_SHOWN)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			results_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		square_t want;
		if (arst_n && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
			if (corner_q.size() == 0) begin
				report_miss("unexpected transaction, square_size", -1, results_ch.square_size);
			end else begin
				want = corner_q.pop_front();
				if (results_ch.square_size !== want.side)
					report_miss("square_size", want.side, results_ch.square_size);
				if (results_ch.bottom_row !== want.row)
					report_miss("bottom_row", want.row, results_ch.bottom_row);
				if (results_ch.right_col !== want.col)
					report_miss("right_col", want.col, results_ch.right_col);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		int start_cells;
		int start_grids;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		cells_ch.valid = 1'b0;
		cells_ch.cell_char = '0;
		results_ch.ready = 1'b0;
		miss_count = 0;
		cycle_count = 0;
		cells_fed = 0;
		grids_fed = 0;
		hold_reqs = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		reg_cols = RST_NUM_COLS;
		reg_rows = RST_NUM_ROWS;
		reg_empty = RST_EMPTY_CHAR;
		for (int i = 0; i < DEF_MAX_COLS; i++)
			side_line[i] = '0;
		diag_side = '0;
		left_side = '0;
		row_at = '0;
		col_at = '0;
		best = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG) begin
				if (i == 0 || DIR_TAB[i-1].kind != ROW_CFG)
					drain_results();
				write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
			end else begin
				cfg_we <= 1'b0;
				feed_cell(DIR_TAB[i].data[CHAR_W-1:0], DIR_TAB[i].typed, DIR_TAB[i].want);
			end
		end

		// one-cell grids while the receiver holds off: the result register fills and
		// the cell input has to stall
		drain_results();
		write_reg(CFG_NUM_COLS, 11'd1);
		write_reg(CFG_NUM_ROWS, 11'd1);
		cfg_we <= 1'b0;
		set_idling(IDLE_NONE);
		hold_reqs <= hold_reqs + 1;
		repeat (40) feed_cell(8'($urandom_range(255)), 1'b0, '0);

		for (int m = 0; m < 4; m++) begin
			set_idling(idle_mode_t'(m));
			start_cells = cells_fed;
			start_grids = grids_fed;
			while (cells_fed - start_cells < 100 || grids_fed - start_grids < 6) begin
				pick_setting();
				repeat ($urandom_range(1, 4))
					feed_grid($urandom_range(0, 500), $urandom_range(7) == 0);
			end
		end

		drain_results();
		repeat (END_PAD) @(posedge clk);
		if (miss_count == 0 && corner_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lesf_pkg.sv
sv/lesf_if.sv
sv/lesf_ram.sv
sv/lesf_scan.sv
sv/lesf_core.sv
sv/largest_empty_square_finder.sv
bench/tb_top.sv
